/* src/ipaft_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// IP address filter table package
// Shared types and constants for the ban table core.
// ----------------------------------------------------------------------------
package ipaft_pkg;

   localparam int unsigned SINGLE_DEPTH_DEF = 256;
   localparam int unsigned RANGE_DEPTH_DEF  = 64;
   localparam int unsigned PREFIX_DEPTH_DEF = 64;

   typedef enum logic [2:0] {
      OP_LOOKUP    = 3'd0,
      OP_ADD_SINGLE = 3'd1,
      OP_ADD_RANGE = 3'd2,
      OP_ADD_MASK  = 3'd3,
      OP_CLEAR     = 3'd4
   } opcode_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [31:0] addr_a;
      logic [31:0] addr_b;
   } req_type;

   typedef struct packed {
      logic hit;
      logic status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SINGLE,
      ST_RANGE,
      ST_PREFIX,
      ST_WRITE,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

/* src/ip_address_filter_table_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// IP address filter table core
// Single, range and prefix ban stores scanned by one shared compare unit.
// ----------------------------------------------------------------------------
// Operation: a lookup walks the range, single and prefix stores in that order
//   and stops at the first hit; an add walks one store, stopping early on a hit,
//   then passes through a write state; a clear goes straight to the result.
// A new word is taken only when idle; busy stays high until the result.
// Reset empties all three stores at once (counts to zero); the receiver cannot stall.
// ----------------------------------------------------------------------------
module ip_address_filter_table_core
   import ipaft_pkg::*;
#(
   parameter int unsigned SINGLE_DEPTH = SINGLE_DEPTH_DEF,
   parameter int unsigned RANGE_DEPTH  = RANGE_DEPTH_DEF,
   parameter int unsigned PREFIX_DEPTH = PREFIX_DEPTH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   localparam int SW = (SINGLE_DEPTH > 1) ? $clog2(SINGLE_DEPTH) : 1;
   localparam int RW = (RANGE_DEPTH > 1) ? $clog2(RANGE_DEPTH) : 1;
   localparam int PW = (PREFIX_DEPTH > 1) ? $clog2(PREFIX_DEPTH) : 1;
   localparam int SC = $clog2(SINGLE_DEPTH + 1);
   localparam int RC = $clog2(RANGE_DEPTH + 1);
   localparam int PC = $clog2(PREFIX_DEPTH + 1);
   localparam int IW = (SC > RC) ? ((SC > PC) ? SC : PC) : ((RC > PC) ? RC : PC);

   logic [31:0] single_mem [SINGLE_DEPTH];
   logic [31:0] rstart_mem [RANGE_DEPTH];
   logic [31:0] rend_mem   [RANGE_DEPTH];
   logic [31:0] pval_mem   [PREFIX_DEPTH];
   logic [31:0] pmask_mem  [PREFIX_DEPTH];

   state_type   state_ff, state_in;
   logic [2:0]  op_ff;
   logic [31:0] a_ff, b_ff;
   logic [SC-1:0] scnt_ff;
   logic [RC-1:0] rcnt_ff;
   logic [PC-1:0] pcnt_ff;
   logic [IW-1:0] idx_ff, idx_in;
   logic        rd_ok_ff;           // read data of the previous index is valid
   logic [IW-1:0] rd_idx_ff;
   logic [31:0] rd0_ff, rd1_ff;
   logic        hit_ff, status_ff, found_ff;
   logic [IW-1:0] found_idx_ff;
   logic [31:0] new0_ff, new1_ff;   // merged entry to write back
   logic        wr_app_ff;          // append instead of in-place update

   logic [IW-1:0] cnt_cur;
   logic        last_issue;
   logic        scan_st;
   logic        match;
   logic [31:0] m0, m1;
   logic        mupd;               // match needs a write back
   logic [31:0] lo, hi, pv;

   assign lo = (a_ff < b_ff) ? a_ff : b_ff;
   assign hi = (a_ff < b_ff) ? b_ff : a_ff;
   assign pv = a_ff & b_ff;

   assign scan_st = (state_ff == ST_SINGLE) || (state_ff == ST_RANGE) ||
                    (state_ff == ST_PREFIX);

   always_comb begin
      case (state_ff)
         ST_SINGLE: cnt_cur = IW'(scnt_ff);
         ST_RANGE:  cnt_cur = IW'(rcnt_ff);
         ST_PREFIX: cnt_cur = IW'(pcnt_ff);
         default:   cnt_cur = '0;
      endcase
   end

   assign last_issue = (idx_ff >= cnt_cur);

   // shared compare on the registered read word
   always_comb begin
      match = 1'b0;
      mupd  = 1'b0;
      m0    = rd0_ff;
      m1    = rd1_ff;
      case (state_ff)
         ST_SINGLE: begin
            match = (rd0_ff == a_ff);
         end
         ST_RANGE: begin
            if (op_ff == OP_LOOKUP) begin
               match = (a_ff >= rd0_ff) && (a_ff <= rd1_ff);
            end else begin
               match = !((hi < rd0_ff) || (lo > rd1_ff));
               mupd  = 1'b1;
               m0    = (lo < rd0_ff) ? lo : rd0_ff;
               m1    = (hi > rd1_ff) ? hi : rd1_ff;
            end
         end
         ST_PREFIX: begin
            if (op_ff == OP_LOOKUP) begin
               match = ((a_ff & rd1_ff) == rd0_ff);
            end else if (rd0_ff == pv) begin
               if ((b_ff & rd1_ff) == b_ff) begin
                  match = 1'b1;
               end else if ((b_ff & rd1_ff) == rd1_ff) begin
                  match = 1'b1;
                  mupd  = 1'b1;
                  m1    = b_ff;
               end
            end
         end
         default: ;
      endcase
   end

   logic hit_now;
   assign hit_now = rd_ok_ff && match && !found_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               idx_in = '0;
               case (req_data.opcode)
                  OP_LOOKUP:     state_in = ST_RANGE;
                  OP_ADD_SINGLE: state_in = ST_SINGLE;
                  OP_ADD_RANGE:  state_in = (req_data.addr_a == req_data.addr_b) ?
                                            ST_SINGLE : ST_RANGE;
                  OP_ADD_MASK:   state_in = ST_PREFIX;
                  default:       state_in = ST_DONE;
               endcase
            end
         end
         ST_SINGLE, ST_RANGE, ST_PREFIX: begin
            if (hit_now || found_ff || (last_issue && !rd_ok_ff)) begin
               idx_in = '0;
               if (op_ff == OP_LOOKUP && !hit_now && !found_ff && state_ff == ST_RANGE)
                  state_in = ST_SINGLE;
               else if (op_ff == OP_LOOKUP && !hit_now && !found_ff &&
                        state_ff == ST_SINGLE)
                  state_in = ST_PREFIX;
               else if (op_ff == OP_LOOKUP)
                  state_in = ST_DONE;
               else
                  state_in = ST_WRITE;
            end else if (!last_issue) begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_WRITE: state_in = ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         scnt_ff  <= '0;
         rcnt_ff  <= '0;
         pcnt_ff  <= '0;
         rd_ok_ff <= 1'b0;
         found_ff <= 1'b0;
         hit_ff   <= 1'b0;
         status_ff <= 1'b0;
         wr_app_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         rd_ok_ff <= scan_st && !last_issue && !hit_now && !found_ff && (state_in == state_ff);
         if (state_ff == ST_IDLE && start) begin
            op_ff     <= req_data.opcode;
            a_ff      <= req_data.addr_a;
            b_ff      <= req_data.addr_b;
            found_ff  <= 1'b0;
            hit_ff    <= 1'b0;
            status_ff <= 1'b0;
            wr_app_ff <= 1'b0;
            if (req_data.opcode == OP_CLEAR) begin
               scnt_ff <= '0;
               rcnt_ff <= '0;
               pcnt_ff <= '0;
            end
         end
         if (scan_st) begin
            rd_idx_ff <= idx_ff;
            if (hit_now) begin
               if (op_ff != OP_LOOKUP) found_ff <= 1'b1;
               // all ones marks nothing to write
               found_idx_ff <= mupd ? rd_idx_ff : '1;
               new0_ff      <= m0;
               new1_ff      <= m1;
               if (op_ff == OP_LOOKUP) hit_ff <= 1'b1;
            end
            if (state_in == ST_WRITE && !hit_now && !found_ff) begin
               wr_app_ff <= 1'b1;
               if (state_ff == ST_RANGE) begin
                  new0_ff <= lo;
                  new1_ff <= hi;
               end else if (state_ff == ST_PREFIX) begin
                  new0_ff <= pv;
                  new1_ff <= b_ff;
               end else begin
                  new0_ff <= (op_ff == OP_ADD_RANGE) ? lo : a_ff;
               end
            end
         end
         if (state_ff == ST_WRITE && wr_app_ff) begin
            case (op_ff)
               OP_ADD_SINGLE, OP_ADD_RANGE: begin
                  if (op_ff == OP_ADD_RANGE && a_ff != b_ff) begin
                     if (rcnt_ff >= RC'(RANGE_DEPTH)) status_ff <= 1'b1;
                     else rcnt_ff <= rcnt_ff + 1'b1;
                  end else begin
                     if (scnt_ff >= SC'(SINGLE_DEPTH)) status_ff <= 1'b1;
                     else scnt_ff <= scnt_ff + 1'b1;
                  end
               end
               OP_ADD_MASK: begin
                  if (pcnt_ff >= PC'(PREFIX_DEPTH)) status_ff <= 1'b1;
                  else pcnt_ff <= pcnt_ff + 1'b1;
               end
               default: ;
            endcase
         end
      end
   end

   // write back in ST_WRITE
   logic wr_single, wr_range, wr_prefix, upd_ok;
   logic [IW-1:0] wr_idx;
   assign upd_ok = found_ff && (found_idx_ff != '1);
   always_comb begin
      wr_single = 1'b0;
      wr_range  = 1'b0;
      wr_prefix = 1'b0;
      wr_idx    = found_idx_ff;
      if (state_ff == ST_WRITE) begin
         if (op_ff == OP_ADD_SINGLE || (op_ff == OP_ADD_RANGE && a_ff == b_ff)) begin
            wr_single = wr_app_ff && (scnt_ff < SC'(SINGLE_DEPTH));
            wr_idx    = IW'(scnt_ff);
         end else if (op_ff == OP_ADD_RANGE) begin
            wr_range = wr_app_ff ? (rcnt_ff < RC'(RANGE_DEPTH)) : upd_ok;
            if (wr_app_ff) wr_idx = IW'(rcnt_ff);
         end else if (op_ff == OP_ADD_MASK) begin
            wr_prefix = wr_app_ff ? (pcnt_ff < PC'(PREFIX_DEPTH)) : upd_ok;
            if (wr_app_ff) wr_idx = IW'(pcnt_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_single) single_mem[wr_idx[SW-1:0]] <= new0_ff;
      case (state_ff)
         ST_SINGLE: begin
            rd0_ff <= single_mem[idx_ff[SW-1:0]];
            rd1_ff <= 32'd0;
         end
         ST_RANGE: begin
            rd0_ff <= rstart_mem[idx_ff[RW-1:0]];
            rd1_ff <= rend_mem[idx_ff[RW-1:0]];
         end
         ST_PREFIX: begin
            rd0_ff <= pval_mem[idx_ff[PW-1:0]];
            rd1_ff <= pmask_mem[idx_ff[PW-1:0]];
         end
         default: begin
            rd0_ff <= 32'd0;
            rd1_ff <= 32'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_range) begin
         rstart_mem[wr_idx[RW-1:0]] <= new0_ff;
         rend_mem[wr_idx[RW-1:0]]   <= new1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_prefix) begin
         pval_mem[wr_idx[PW-1:0]]  <= new0_ff;
         pmask_mem[wr_idx[PW-1:0]] <= new1_ff;
      end
   end

   always_comb begin
      busy            = (state_ff != ST_IDLE);
      rsp_valid       = (state_ff == ST_DONE);
      rsp_data.hit    = hit_ff;
      rsp_data.status = status_ff;
   end

endmodule
`default_nettype wire

/* bench/tb_ip_address_filter_table_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// IP address filter table core testbench
// Drives lookup, add, clear and unused commands from a queue with random gaps,
// predicts hit and status from a local copy of the ban stores, and checks
// every result word against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_ip_address_filter_table_core;
   import ipaft_pkg::*;

   localparam int unsigned NSINGLE = SINGLE_DEPTH_DEF;
   localparam int unsigned NRANGE  = RANGE_DEPTH_DEF;
   localparam int unsigned NPREFIX = PREFIX_DEPTH_DEF;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   ip_address_filter_table_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   // shadow ban stores
   logic [31:0] ban_single [NSINGLE];
   int unsigned ban_single_n = 0;
   logic [31:0] ban_lo [NRANGE];
   logic [31:0] ban_hi [NRANGE];
   int unsigned ban_range_n = 0;
   logic [31:0] ban_val [NPREFIX];
   logic [31:0] ban_msk [NPREFIX];
   int unsigned ban_prefix_n = 0;

   req_type pending_words[$];
   rsp_type expected_rsps[$];
   int unsigned mismatches = 0;

   task automatic queue_word(req_type w);
      pending_words = {pending_words, w};
   endtask

   function automatic bit single_has(logic [31:0] a);
      for (int unsigned i = 0; i < ban_single_n; i++)
         if (ban_single[i] == a) return 1'b1;
      return 1'b0;
   endfunction

   function automatic logic put_single(logic [31:0] a);
      if (single_has(a)) return 1'b0;
      if (ban_single_n >= NSINGLE) return 1'b1;
      ban_single[ban_single_n] = a;
      ban_single_n++;
      return 1'b0;
   endfunction

   function automatic rsp_type predict_filter(req_type w);
      rsp_type r;
      logic [31:0] lo, hi, v;
      r = '0;
      case (w.opcode)
         OP_LOOKUP: begin
            r.hit = single_has(w.addr_a);
            for (int unsigned i = 0; i < ban_range_n; i++)
               if (w.addr_a >= ban_lo[i] && w.addr_a <= ban_hi[i]) r.hit = 1'b1;
            for (int unsigned i = 0; i < ban_prefix_n; i++)
               if ((w.addr_a & ban_msk[i]) == ban_val[i]) r.hit = 1'b1;
         end
         OP_ADD_SINGLE: r.status = put_single(w.addr_a);
         OP_ADD_RANGE: begin
            lo = (w.addr_a < w.addr_b) ? w.addr_a : w.addr_b;
            hi = (w.addr_a < w.addr_b) ? w.addr_b : w.addr_a;
            if (lo == hi) return '{hit: 1'b0, status: put_single(lo)};
            for (int unsigned i = 0; i < ban_range_n; i++) begin
               if (hi < ban_lo[i] || lo > ban_hi[i]) continue;
               if (hi > ban_hi[i]) ban_hi[i] = hi;
               if (lo < ban_lo[i]) ban_lo[i] = lo;
               return r;
            end
            if (ban_range_n >= NRANGE) r.status = 1'b1;
            else begin
               ban_lo[ban_range_n] = lo;
               ban_hi[ban_range_n] = hi;
               ban_range_n++;
            end
         end
         OP_ADD_MASK: begin
            v = w.addr_a & w.addr_b;
            for (int unsigned i = 0; i < ban_prefix_n; i++) begin
               if (ban_val[i] != v) continue;
               if ((w.addr_b & ban_msk[i]) == w.addr_b) return r;
               if ((w.addr_b & ban_msk[i]) == ban_msk[i]) begin
                  ban_msk[i] = w.addr_b;
                  return r;
               end
            end
            if (ban_prefix_n >= NPREFIX) r.status = 1'b1;
            else begin
               ban_val[ban_prefix_n] = v;
               ban_msk[ban_prefix_n] = w.addr_b;
               ban_prefix_n++;
            end
         end
         OP_CLEAR: begin
            ban_single_n = 0;
            ban_range_n = 0;
            ban_prefix_n = 0;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic req_type mk_word(logic [2:0] op, logic [31:0] a, logic [31:0] b);
      req_type w;
      w.opcode = op;
      w.addr_a = a;
      w.addr_b = b;
      return w;
   endfunction

   // addresses drawn from a small pool so that merges and hits are common
   function automatic logic [31:0] pick_addr();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return {24'hC0A800, 8'($urandom_range(0, 63))};
         2: return {8'd10, 16'h0, 8'($urandom_range(0, 255))};
         default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 3)
                                               : $urandom_range(0, 3);
      endcase
   endfunction

   function automatic logic [31:0] pick_mask();
      int unsigned n;
      n = $urandom_range(0, 32);
      if ($urandom_range(0, 7) == 0) return $urandom();
      return (n == 0) ? 32'h0 : 32'(~((64'd1 << (32 - n)) - 64'd1));
   endfunction

   function automatic req_type random_word();
      int unsigned k;
      k = $urandom_range(0, 99);
      if (k < 40) return mk_word(OP_LOOKUP, pick_addr(), $urandom());
      if (k < 58) return mk_word(OP_ADD_SINGLE, pick_addr(), $urandom());
      if (k < 76) return mk_word(OP_ADD_RANGE, pick_addr(), pick_addr());
      if (k < 94) return mk_word(OP_ADD_MASK, pick_addr(), pick_mask());
      if (k < 97) return mk_word(OP_CLEAR, $urandom(), $urandom());
      return mk_word(3'($urandom_range(5, 7)), $urandom(), $urandom());
   endfunction

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   initial begin
      // directed: every operation, extremes, merges, mask zero, unused codes
      queue_word(mk_word(OP_LOOKUP, 32'h0, 32'h0));
      queue_word(mk_word(OP_ADD_SINGLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      queue_word(mk_word(OP_ADD_SINGLE, 32'hFFFF_FFFF, 32'h0));
      queue_word(mk_word(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0));
      queue_word(mk_word(OP_ADD_RANGE, 32'h200, 32'h100));
      queue_word(mk_word(OP_ADD_RANGE, 32'h180, 32'h300));
      queue_word(mk_word(OP_ADD_RANGE, 32'h50, 32'h120));
      queue_word(mk_word(OP_ADD_RANGE, 32'h7, 32'h7));
      queue_word(mk_word(OP_LOOKUP, 32'h7, 32'h0));
      queue_word(mk_word(OP_LOOKUP, 32'h300, 32'h0));
      queue_word(mk_word(OP_LOOKUP, 32'h301, 32'h0));
      queue_word(mk_word(OP_ADD_MASK, 32'hC0A8_01FF, 32'hFFFF_FF00));
      queue_word(mk_word(OP_ADD_MASK, 32'hC0A8_0100, 32'hFFFF_FFF0));
      queue_word(mk_word(OP_ADD_MASK, 32'hC0A8_0100, 32'hFFFF_0000));
      queue_word(mk_word(OP_LOOKUP, 32'hC0A8_0123, 32'h0));
      queue_word(mk_word(OP_ADD_MASK, 32'h1234_5678, 32'h0));
      queue_word(mk_word(OP_LOOKUP, 32'h8765_4321, 32'h0));
      queue_word(mk_word(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      queue_word(mk_word(3'd7, 32'h0, 32'h0));
      queue_word(mk_word(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      queue_word(mk_word(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0));
      // fill each store to its limit, then overflow it
      for (int unsigned i = 0; i <= NSINGLE; i++)
         queue_word(mk_word(OP_ADD_SINGLE, 32'hA000_0000 + i, 32'h0));
      for (int unsigned i = 0; i <= NRANGE; i++)
         queue_word(mk_word(OP_ADD_RANGE, 32'hB000_0000 + 16 * i,
                            32'hB000_0004 + 16 * i));
      for (int unsigned i = 0; i <= NPREFIX; i++)
         queue_word(mk_word(OP_ADD_MASK, 32'hD000_0000 + 256 * i,
                            32'hFFFF_FF00));
      queue_word(mk_word(OP_ADD_SINGLE, 32'hA000_0003, 32'h0));
      queue_word(mk_word(OP_ADD_RANGE, 32'hB000_0002, 32'hB000_0008));
      queue_word(mk_word(OP_ADD_MASK, 32'hD000_0000, 32'hFFFF_0000));
      queue_word(mk_word(OP_LOOKUP, 32'hD000_3F12, 32'h0));
      queue_word(mk_word(OP_CLEAR, 32'h0, 32'h0));
      for (int unsigned i = 0; i < 1340; i++) queue_word(random_word());
   end

   // driver: pause once midway until every prediction has been checked
   int unsigned gap_left = 0;
   int unsigned sent = 0;
   bit drain_done = 1'b0;
   logic busy_at_edge = 1'b0;
   rsp_type predicted;

   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy_at_edge) begin
         // word taken at the last rising edge; hold start low for the gap
         start <= 1'b0;
      end else if (!start) begin
         if (sent == 600 && !drain_done) begin
            if (expected_rsps.size() == 0 && !busy) drain_done <= 1'b1;
         end else if (gap_left != 0) begin
            gap_left <= gap_left - 1;
         end else if (pending_words.size() != 0) begin
            req_data <= pending_words.pop_front();
            start <= 1'b1;
            gap_left <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 7);
         end
      end
   end

   // sample handshake and results at the rising edge
   always @(posedge clock) begin
      busy_at_edge <= busy;
      if (!reset && start && !busy) begin
         expected_rsps = {expected_rsps, predict_filter(req_data)};
         sent <= sent + 1;
      end
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word hit=%0b status=%0b",
                                           rsp_data.hit, rsp_data.status);
         end else begin
            predicted = expected_rsps.pop_front();
            if (predicted !== rsp_data) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected hit=%0b status=%0b, got hit=%0b status=%0b",
                           predicted.hit, predicted.status, rsp_data.hit, rsp_data.status);
            end
         end
      end
   end

   initial begin
      wait (!reset);
      wait (pending_words.size() == 0 && !start && expected_rsps.size() == 0);
      repeat (400) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #100000000;
      $display("tb: failure");
      $finish;
   end

endmodule
`default_nettype wire

/* ip_address_filter_table_core.f */
src/ipaft_pkg.sv
src/ip_address_filter_table_core.sv
bench/tb_ip_address_filter_table_core.sv
